// ===== src/ppdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdf_pkg
// Shared types, register codes and helpers for the PID controller with
// positional / incremental modes and setpoint feedforward.
// ----------------------------------------------------------------------------
package ppdf_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_GAIN_FF   = 3'd4,
    REG_LIMIT_OUT = 3'd5,
    REG_LIMIT_INT = 3'd6
  } ppdf_reg_e;

  localparam int unsigned IndexWidth = 3;
  localparam int unsigned DataWidth  = 16;
  localparam int unsigned FracBits   = 8;

  // Current register contents, handed from the register file to the datapath
  typedef struct packed {
    logic        mode_incremental;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] gain_ff;
    logic [14:0] limit_out;
    logic [14:0] limit_integral;
  } ppdf_cfg_t;

  // Symmetric clamp of a wide Q.8 value against +/- lim (lim already in Q.8)
  function automatic logic signed [39:0] clamp_sym(logic signed [39:0] v,
                                                    logic [22:0] lim);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = $signed({17'd0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ===== src/ppdf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppdf_cfg_regs
// Configuration register file: mode, four Q8.8 gains and two limits.
// ----------------------------------------------------------------------------
module ppdf_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppdf_pkg::IndexWidth-1:0]     cfg_index_i,
  input  logic [ppdf_pkg::DataWidth-1:0]      cfg_data_i,
  output ppdf_pkg::ppdf_cfg_t                 cfg_o
);

  ppdf_pkg::ppdf_cfg_t cfg_q;
  ppdf_pkg::ppdf_cfg_t cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register decode; unknown indexes leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ppdf_pkg::REG_MODE:      cfg_d.mode_incremental = cfg_data_i[0];
        ppdf_pkg::REG_GAIN_P:    cfg_d.gain_p           = cfg_data_i;
        ppdf_pkg::REG_GAIN_I:    cfg_d.gain_i           = cfg_data_i;
        ppdf_pkg::REG_GAIN_D:    cfg_d.gain_d           = cfg_data_i;
        ppdf_pkg::REG_GAIN_FF:   cfg_d.gain_ff          = cfg_data_i;
        ppdf_pkg::REG_LIMIT_OUT: cfg_d.limit_out        = cfg_data_i[14:0];
        ppdf_pkg::REG_LIMIT_INT: cfg_d.limit_integral   = cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/pid_position_delta_feedforward.sv =====
// ----------------------------------------------------------------------------
// pid_position_delta_feedforward
// PID controller, positional with setpoint feedforward or incremental,
// unsigned Q8.8 gains, saturating Q.8 accumulators, clamped drive output.
// ----------------------------------------------------------------------------
// Path: an input transfer loads the input register, then the result register
//   takes the drive; multiplies, sum and clamp sit between the two.
// Throughput: one item per cycle; a stalled output holds the result register
//   and then the input register.
// Reset: asynchronous, clears the error history, integral, held output and
//   previous setpoint to zero and empties both stages; stage data is not reset.
// ----------------------------------------------------------------------------
module pid_position_delta_feedforward (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppdf_pkg::IndexWidth-1:0]     cfg_index_i,
  input  logic [ppdf_pkg::DataWidth-1:0]      cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [15:0]                  setpoint_i,
  input  logic signed [15:0]                  measured_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  drive_o
);

  ppdf_pkg::ppdf_cfg_t cfg;

  ppdf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // Flow control: input register, then result register
  // --------------------------------------------------------------------------
  logic v1_q, v2_q;
  logic v1_d, v2_d;
  logic rdy1, rdy2;
  logic ld1, ld2;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign ld1 = in_valid_i && rdy1;
  assign ld2 = v1_q && rdy2;

  always_comb begin
    v1_d = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_q);
    v2_d = ld2 ? 1'b1 : (out_ready_i ? 1'b0 : v2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: error and differences; error history updates on every transfer
  // --------------------------------------------------------------------------
  logic signed [16:0] err_prev1_q, err_prev2_q;
  logic signed [15:0] prev_sp_q;
  logic signed [16:0] err_d;
  logic signed [17:0] derr_d;
  logic signed [18:0] dderr_d;
  logic signed [16:0] dsp_d;

  logic signed [16:0] s1_err_q;
  logic signed [17:0] s1_derr_q;
  logic signed [18:0] s1_dderr_q;
  logic signed [16:0] s1_dsp_q;
  logic               s1_inc_q;

  always_comb begin
    err_d   = 17'(setpoint_i) - 17'(measured_i);
    derr_d  = 18'(err_d) - 18'(err_prev1_q);
    dderr_d = 19'(err_d) - (19'(err_prev1_q) <<< 1) + 19'(err_prev2_q);
    dsp_d   = 17'(setpoint_i) - 17'(prev_sp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_prev1_q <= '0;
      err_prev2_q <= '0;
      prev_sp_q   <= '0;
    end else if (ld1) begin
      err_prev1_q <= err_d;
      err_prev2_q <= err_prev1_q;
      // setpoint memory follows positional steps only
      if (!cfg.mode_incremental) begin
        prev_sp_q <= setpoint_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_err_q   <= err_d;
      s1_derr_q  <= derr_d;
      s1_dderr_q <= dderr_d;
      s1_dsp_q   <= dsp_d;
      s1_inc_q   <= cfg.mode_incremental;
    end
  end

  // --------------------------------------------------------------------------
  // Gain products (Q.8), straight off the input register
  // --------------------------------------------------------------------------
  logic signed [17:0] op_p;
  logic signed [18:0] op_d;
  logic signed [34:0] prod_p_d;
  logic signed [35:0] prod_d_d;
  logic signed [33:0] prod_i_d;
  logic signed [33:0] prod_f_d;

  always_comb begin
    // incremental mode works on the first and second differences
    op_p     = s1_inc_q ? s1_derr_q : 18'(s1_err_q);
    op_d     = s1_inc_q ? s1_dderr_q : 19'(s1_derr_q);
    prod_p_d = $signed({1'b0, cfg.gain_p}) * op_p;
    prod_d_d = $signed({1'b0, cfg.gain_d}) * op_d;
    prod_i_d = $signed({1'b0, cfg.gain_i}) * s1_err_q;
    prod_f_d = $signed({1'b0, cfg.gain_ff}) * s1_dsp_q;
  end

  // --------------------------------------------------------------------------
  // Result stage: integral, sum, clamp and drive
  // --------------------------------------------------------------------------
  logic signed [31:0] integral_q;
  logic signed [23:0] held_q;
  logic signed [39:0] isum;
  logic signed [39:0] iclamp;
  logic signed [31:0] isat;
  logic signed [39:0] base;
  logic signed [39:0] total;
  logic signed [39:0] res40;
  logic signed [23:0] res;
  logic               round_up;
  logic signed [15:0] drive_d;
  logic signed [15:0] drive_q;

  always_comb begin
    isum   = 40'(integral_q) + 40'(prod_i_d);
    iclamp = ppdf_pkg::clamp_sym(isum, {cfg.limit_integral, 8'h00});

    // incremental mode overwrites the integral with the saturated product
    if (prod_i_d > 34'sh0_7FFF_FFFF) begin
      isat = 32'sh7FFF_FFFF;
    end else if (prod_i_d < -34'sh0_8000_0000) begin
      isat = 32'sh8000_0000;
    end else begin
      isat = prod_i_d[31:0];
    end

    if (s1_inc_q) begin
      base = 40'(held_q) + 40'(prod_i_d);
    end else begin
      base = iclamp + 40'(prod_f_d);
    end
    total = base + 40'(prod_p_d) + 40'(prod_d_d);
    res40 = ppdf_pkg::clamp_sym(total, {cfg.limit_out, 8'h00});
    res   = res40[23:0];

    // integer part, truncated toward zero
    round_up = res[23] && (res[ppdf_pkg::FracBits-1:0] != '0);
    drive_d  = res[23:8] + {15'd0, round_up};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      held_q     <= '0;
    end else if (ld2) begin
      integral_q <= s1_inc_q ? isat : iclamp[31:0];
      held_q     <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = v2_q;
  assign drive_o     = drive_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no transfer into a full input register that cannot drain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |-> !in_ready_o)
    else $error("input taken while the input register is blocked");

  // held output never leaves the widest possible output range
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q <= 24'sd8388352) && (held_q >= -24'sd8388352))
    else $error("held output out of range");

  // a positional step leaves the integral inside its limit
  a_int_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld2 && !s1_inc_q) |=>
      (integral_q <= $signed({9'd0, $past(cfg.limit_integral), 8'h00})) &&
      (integral_q >= -$signed({9'd0, $past(cfg.limit_integral), 8'h00})))
    else $error("integral beyond its limit after a positional step");

  // the drive can never be the most negative code
  a_drive_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o != 16'sh8000))
    else $error("drive outside symmetric range");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional / incremental PID controller with
// setpoint feedforward. A cycle-free predictor mirrors the register file and
// the controller state. It forms the expected drive for every input transfer,
// and a checker compares each output transfer against the oldest expected
// value. The directed tests cover extreme inputs, both modes, saturating
// integrals, lowered and zero limits and an unused register index. The
// random phases follow, two of them with randomized idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned           ResetCycles = 6;
  localparam int unsigned           TailCycles  = 10;
  localparam longint                TimeoutNs   = 5_000_000;
  localparam int unsigned           ItemsPerPhase = 350;
  localparam logic [ppdf_pkg::IndexWidth-1:0] RegUnused = '1;

  // Clock, reset and DUT ports
  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [ppdf_pkg::IndexWidth-1:0]      cfg_index_i = '0;
  logic [ppdf_pkg::DataWidth-1:0]       cfg_data_i  = '0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic signed [15:0]                   setpoint_i  = '0;
  logic signed [15:0]                   measured_i  = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic signed [15:0]                   drive_o;

  pid_position_delta_feedforward u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  always #6 clk_i = ~clk_i;

  // Bookkeeping
  logic signed [15:0] drive_expected_q[$];
  logic signed [15:0] drive_oldest;
  int unsigned        mismatch_count  = 0;
  int unsigned        items_sent      = 0;
  int unsigned        drives_checked  = 0;
  int unsigned        cfg_writes_done = 0;
  int unsigned        tx_idle_pct     = 0;
  int unsigned        rx_idle_pct     = 0;

  // --------------------------------------------------------------------------
  // Controller predictor: register shadow plus error history, integral,
  // held output and last positional setpoint (Q.8 where noted)
  // --------------------------------------------------------------------------
  ppdf_pkg::ppdf_cfg_t cfg_shadow = '0;
  longint    err_last   = 0;
  longint    err_older  = 0;
  longint    integ_q8   = 0;
  longint    held_q8    = 0;
  longint    sp_last    = 0;

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint sat_int32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void shadow_write(logic [ppdf_pkg::IndexWidth-1:0] idx,
                                       logic [ppdf_pkg::DataWidth-1:0] data);
    case (idx)
      ppdf_pkg::REG_MODE:      cfg_shadow.mode_incremental = data[0];
      ppdf_pkg::REG_GAIN_P:    cfg_shadow.gain_p = data;
      ppdf_pkg::REG_GAIN_I:    cfg_shadow.gain_i = data;
      ppdf_pkg::REG_GAIN_D:    cfg_shadow.gain_d = data;
      ppdf_pkg::REG_GAIN_FF:   cfg_shadow.gain_ff = data;
      ppdf_pkg::REG_LIMIT_OUT: cfg_shadow.limit_out = data[14:0];
      ppdf_pkg::REG_LIMIT_INT: cfg_shadow.limit_integral = data[14:0];
      default: ; // unused index, write dropped
    endcase
  endfunction

  // One controller step; updates the predictor state, returns the drive
  function automatic logic signed [15:0] pid_predict(logic signed [15:0] sp,
                                                     logic signed [15:0] ms);
    longint e;
    longint lim_o;
    longint lim_i;
    longint kp;
    longint ki;
    longint kd;
    longint acc;
    longint sum;
    longint res;
    longint whole;
    e     = longint'(sp) - longint'(ms);
    lim_o = longint'(cfg_shadow.limit_out) * 256;
    lim_i = longint'(cfg_shadow.limit_integral) * 256;
    kp    = longint'(cfg_shadow.gain_p);
    ki    = longint'(cfg_shadow.gain_i);
    kd    = longint'(cfg_shadow.gain_d);
    if (!cfg_shadow.mode_incremental) begin
      acc = clamp_mag(integ_q8 + ki * e, lim_i);
      sum = kp * e + acc + kd * (e - err_last)
            + longint'(cfg_shadow.gain_ff) * (longint'(sp) - sp_last);
      integ_q8 = acc;
      res = clamp_mag(sum, lim_o);
      sp_last = longint'(sp);
    end else begin
      // integral is overwritten, not accumulated, in this mode
      integ_q8 = sat_int32(ki * e);
      sum = held_q8 + kp * (e - err_last) + ki * e
            + kd * (e - 2 * err_last + err_older);
      res = clamp_mag(sum, lim_o);
    end
    held_q8   = res;
    err_older = err_last;
    err_last  = e;
    whole     = res / 256; // truncates toward zero
    return whole[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH %0d: %s", mismatch_count, msg);
  endtask

  // Send one item; valid stays high afterwards so a back-to-back item can follow
  task automatic send_item(input logic signed [15:0] sp, input logic signed [15:0] ms);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    drive_expected_q.push_back(pid_predict(sp, ms));
    items_sent++;
  endtask

  // Drop valid and hold off until every expected drive has come back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [ppdf_pkg::IndexWidth-1:0] idx,
                           input logic [ppdf_pkg::DataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, data);
    cfg_writes_done++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram every register once the pipeline has emptied
  task automatic program_controller(input logic mode, input logic [15:0] kp,
                                    input logic [15:0] ki, input logic [15:0] kd,
                                    input logic [15:0] kf, input logic [14:0] lim_out,
                                    input logic [14:0] lim_int);
    wait_all_results();
    repeat (4) @(posedge clk_i);
    cfg_write(ppdf_pkg::REG_MODE, {15'($urandom), mode});
    cfg_write(ppdf_pkg::REG_GAIN_P, kp);
    cfg_write(ppdf_pkg::REG_GAIN_I, ki);
    cfg_write(ppdf_pkg::REG_GAIN_D, kd);
    cfg_write(ppdf_pkg::REG_GAIN_FF, kf);
    cfg_write(ppdf_pkg::REG_LIMIT_OUT, {1'($urandom), lim_out});
    cfg_write(ppdf_pkg::REG_LIMIT_INT, {1'($urandom), lim_int});
  endtask

  // Output checker and receiver stall generator
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_expected_q.size() == 0) begin
        flag_error($sformatf("unexpected drive transfer, actual %0d", drive_o));
      end else begin
        drive_oldest = drive_expected_q.pop_front();
        drives_checked++;
        if (drive_o !== drive_oldest) begin
          flag_error($sformatf("drive expected %0d actual %0d", drive_oldest, drive_o));
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers are all zero: drive must stay at zero for extreme errors
  task automatic test_reset_state();
    send_item(16'sh7FFF, -16'sh8000);
    send_item(-16'sh8000, 16'sh7FFF);
  endtask

  // Positional mode: P, I, D and setpoint feedforward, then full-scale gains
  task automatic test_positional();
    program_controller(1'b0, 16'h0100, 16'h0080, 16'h0200, 16'h0040, 15'h7FFF, 15'h7FFF);
    send_item(16'sd100, 16'sd0);
    send_item(16'sd100, 16'sd40);
    send_item(-16'sd300, 16'sd25);
    send_item(16'sd0, 16'sd0);
    program_controller(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    send_item(16'sh7FFF, -16'sh8000);
    send_item(-16'sh8000, 16'sh7FFF);
    send_item(16'sd1, 16'sd0);
  endtask

  // Incremental mode, including an integral that saturates at 32 bits and a
  // positional step that then accumulates onto it
  task automatic test_incremental();
    program_controller(1'b1, 16'h0100, 16'h0010, 16'h0080, 16'h0000, 15'h7FFF, 15'h7FFF);
    send_item(16'sd500, 16'sd0);
    send_item(16'sd500, 16'sd200);
    send_item(16'sd500, 16'sd480);
    program_controller(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 15'h7FFF, 15'h7FFF);
    send_item(16'sh7FFF, -16'sh8000);
    program_controller(1'b0, 16'h0000, 16'h0001, 16'h0000, 16'h0100, 15'h7FFF, 15'h0100);
    send_item(-16'sd10, 16'sd5);
  endtask

  // Lowered limits clamp the held output and the integral on their next use;
  // zero limits force the term to zero
  task automatic test_limit_changes();
    program_controller(1'b1, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 15'h7FFF, 15'h7FFF);
    send_item(16'sd20000, 16'sd0);
    send_item(16'sd20000, 16'sd0);
    program_controller(1'b1, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 15'd1000, 15'h7FFF);
    send_item(16'sd20000, 16'sd0);
    program_controller(1'b1, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 15'd0, 15'h7FFF);
    send_item(16'sd20000, -16'sd3000);
    program_controller(1'b0, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 15'h7FFF, 15'h7FFF);
    send_item(16'sd10000, 16'sd0);
    send_item(16'sd10000, 16'sd0);
    program_controller(1'b0, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 15'h7FFF, 15'd50);
    send_item(16'sd10000, 16'sd0);
    program_controller(1'b0, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 15'h7FFF, 15'd0);
    send_item(-16'sd10000, 16'sd0);
  endtask

  // A write to the unused index must leave every register unchanged
  task automatic test_unused_index();
    program_controller(1'b0, 16'h0180, 16'h0020, 16'h0040, 16'h0100, 15'd20000, 15'd5000);
    cfg_write(RegUnused, 16'hFFFF);
    cfg_write(RegUnused, 16'h0000);
    send_item(16'sd1234, -16'sd777);
    send_item(16'sd1234, 16'sd1000);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(16'h0300));
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    case ($urandom_range(5))
      0:       return 15'd0;
      1, 2:    return 15'h7FFF;
      3:       return 15'($urandom);
      default: return 15'($urandom_range(2000));
    endcase
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // Random segments, each with a fresh register setting; most segments run a
  // tracking loop (measured chases a stepped setpoint), some pure noise
  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned done;
    int unsigned seg_len;
    int unsigned k;
    bit          noisy;
    int          sp_track;
    int          ms_track;
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < ItemsPerPhase) begin
      program_controller(1'($urandom), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                         pick_limit(), pick_limit());
      if ($urandom_range(7) == 0) cfg_write(RegUnused, 16'($urandom));
      seg_len  = $urandom_range(50, 20);
      noisy    = ($urandom_range(3) == 0);
      sp_track = $urandom_range(4000) - 2000;
      ms_track = 0;
      for (k = 0; k < seg_len; k++) begin
        if (noisy || $urandom_range(19) == 0) begin
          sp = 16'($urandom);
          ms = 16'($urandom);
          if ($urandom_range(9) == 0) sp = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
          if ($urandom_range(9) == 0) ms = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
        end else begin
          if ($urandom_range(9) == 0) sp_track = int'($signed(16'($urandom)));
          ms_track = ms_track + (sp_track - ms_track) / 4 + int'($urandom_range(64)) - 32;
          sp = clip16(sp_track);
          ms = clip16(ms_track);
        end
        send_item(sp, ms);
        // hold off once per phase, halfway through, until the pipeline drains
        if (done == ItemsPerPhase / 2) wait_all_results();
        done++;
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(29, 75);
    run_random_phase(75, 29);
    run_random_phase(0, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_positional();
    test_incremental();
    test_limit_changes();
    test_unused_index();
    test_random();

    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);
    if (drive_expected_q.size() != 0) begin
      flag_error($sformatf("%0d drive values never arrived", drive_expected_q.size()));
    end

    $display("Covered: %0d input transfers, %0d drive values checked, %0d register writes",
             items_sent, drives_checked, cfg_writes_done);
    $display("Both modes, extreme inputs and gains, lowered/zero limits, three idling mixes");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("Timeout: %0d drive values still outstanding", drive_expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
